/* rtl/kcev_pkg.sv */
// Package for the keypad code entry verifier.
// Holds request and key codes, register indexes, reset constants and the timer control type.
// No dependencies.
`timescale 1ns / 1ps

package kcev_pkg;

    // Request types
    localparam logic [1:0] REQ_KEY   = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_ISSUE = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // Key codes
    localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
    localparam logic [3:0] KEY_CONFIRM    = 4'd12;
    localparam logic [3:0] KEY_BACKSPACE  = 4'd13;
    localparam logic [3:0] BLANK_DIGIT    = 4'd15;

    // Configuration register indexes
    localparam logic CFG_EXPECTED = 1'b0;
    localparam logic CFG_TIMEOUT  = 1'b1;

    localparam int DISPLAY_DIGITS      = 6;
    localparam int CODE_DIGITS_DEFAULT = 6;
    localparam int TIMER_W             = 32;
    localparam int EXPECTED_W          = 4 * DISPLAY_DIGITS;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 32'd300000;

    typedef struct packed {
        logic tick;
        logic restart;
    } kcev_timer_ctl_t;

endpackage

/* rtl/kcev_timer.sv */
// Elapsed tick counter with saturation and timeout compare.
// Depends on kcev_pkg.
`timescale 1ns / 1ps

module kcev_timer (
    input  logic                     clk,
    input  logic                     rst_n,
    input  kcev_pkg::kcev_timer_ctl_t ctl,
    input  logic [kcev_pkg::TIMER_W-1:0] timeout,
    output logic                     expired_next
);
    import kcev_pkg::*;

    logic [TIMER_W-1:0] elapsed_reg;
    logic [TIMER_W-1:0] elapsed_next;

    always_comb
    begin
        elapsed_next = elapsed_reg;
        if (ctl.restart)
        begin
            elapsed_next = '0;
        end
        else if (ctl.tick && (elapsed_reg != {TIMER_W{1'b1}}))
        begin
            elapsed_next = elapsed_reg + TIMER_W'(1);
        end
    end

    // State after this transaction compared against the timeout
    assign expired_next = (elapsed_next > timeout);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
        end
        else
        begin
            elapsed_reg <= elapsed_next;
        end
    end

`ifndef SYNTHESIS
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.restart |=> (elapsed_reg == '0))
        else $error("elapsed count not cleared after restart");

    a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.tick && !ctl.restart && (elapsed_reg == {TIMER_W{1'b1}}))
        |=> (elapsed_reg == {TIMER_W{1'b1}}))
        else $error("elapsed count wrapped");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!ctl.tick && !ctl.restart) |=> $stable(elapsed_reg))
        else $error("elapsed count moved without a tick");
`endif

endmodule

/* rtl/keypad_code_entry_verifier_core.sv */
// Keypad code entry verifier: top level with entry buffer, config registers and result register.
// Latency: a result is valid the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle; in_ready drops only while a result waits on out_ready.
// Reset: all slots blank, position 0, elapsed count 0, expected code 0, timeout 300000.
// Config writes are always accepted (cfg_ready is tied high). Depends on kcev_pkg, kcev_timer.
`timescale 1ns / 1ps

module keypad_code_entry_verifier_core #(
    parameter int CODE_DIGITS = kcev_pkg::CODE_DIGITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [kcev_pkg::TIMER_W-1:0]    cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      req_type,
    input  logic [3:0]                      key_code,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            confirm_ok,
    output logic                            code_complete,
    output logic                            code_expired,
    output logic                            code_match,
    output logic [2:0]                      entry_position,
    output logic [kcev_pkg::EXPECTED_W-1:0] entered_display
);
    import kcev_pkg::*;

    // Position counts 0..CODE_DIGITS; slot index covers 0..CODE_DIGITS-1
    localparam int PosW = $clog2(CODE_DIGITS + 1);
    localparam int IdxW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam int PadN = (CODE_DIGITS > DISPLAY_DIGITS) ? CODE_DIGITS : DISPLAY_DIGITS;
    localparam logic [PosW-1:0] PosFull = PosW'(CODE_DIGITS);

    // Configuration registers
    logic [EXPECTED_W-1:0] expected_reg;
    logic [TIMER_W-1:0]    timeout_reg;

    // Entry state
    logic [CODE_DIGITS-1:0][3:0] digits_reg;
    logic [CODE_DIGITS-1:0][3:0] digits_next;
    logic [PosW-1:0]             pos_reg;
    logic [PosW-1:0]             pos_next;
    logic [PosW-1:0]             pos_dec;

    // Result register
    logic                  out_valid_reg;
    logic                  confirm_reg;
    logic                  complete_reg;
    logic                  expired_reg;
    logic                  match_reg;
    logic [2:0]            position_reg;
    logic [EXPECTED_W-1:0] display_reg;

    logic                  in_fire;
    logic                  confirm_next;
    logic                  complete_cur;
    logic                  complete_next;
    logic                  digits_equal;
    logic                  expired_next;
    logic [PadN-1:0][3:0]  expected_pad;
    logic [PadN-1:0][3:0]  digits_pad;
    kcev_timer_ctl_t       timer_ctl;

    // Take a new transaction whenever the result register is empty or being drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Configuration writes: index 1 bit covers both registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= '0;
            timeout_reg  <= TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_EXPECTED: expected_reg <= cfg_data[EXPECTED_W-1:0];
                CFG_TIMEOUT:  timeout_reg  <= cfg_data;
                default:      timeout_reg  <= timeout_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Timer: tick and restart apply only on an accepted transaction
    // ---------------------------------------------------------------
    always_comb
    begin
        timer_ctl.tick    = in_fire && (req_type == REQ_TICK);
        timer_ctl.restart = in_fire && (req_type == REQ_ISSUE);
    end

    kcev_timer u_timer (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (timer_ctl),
        .timeout      (timeout_reg),
        .expired_next (expired_next)
    );

    // ---------------------------------------------------------------
    // Entry buffer update
    // ---------------------------------------------------------------
    assign pos_dec = pos_reg - PosW'(1);

    always_comb
    begin
        complete_cur = 1'b1;
        for (int i = 0; i < CODE_DIGITS; i++)
        begin
            if (digits_reg[i] == BLANK_DIGIT)
            begin
                complete_cur = 1'b0;
            end
        end
    end

    always_comb
    begin
        digits_next  = digits_reg;
        pos_next     = pos_reg;
        confirm_next = 1'b0;
        unique case (req_type)
            REQ_KEY:
            begin
                priority if (key_code == KEY_CONFIRM)
                begin
                    confirm_next = complete_cur;
                end
                else if (key_code == KEY_BACKSPACE)
                begin
                    // drop the last digit, if any
                    if (pos_reg != '0)
                    begin
                        pos_next                    = pos_dec;
                        digits_next[pos_dec[IdxW-1:0]] = BLANK_DIGIT;
                    end
                end
                else if ((key_code <= KEY_LAST_DIGIT) && (pos_reg < PosFull))
                begin
                    digits_next[pos_reg[IdxW-1:0]] = key_code;
                    pos_next                       = pos_reg + PosW'(1);
                end
                else
                begin
                    // letters, star, hash, or digit into a full buffer: nothing changes
                    pos_next = pos_reg;
                end
            end
            REQ_CLEAR:
            begin
                for (int i = 0; i < CODE_DIGITS; i++)
                begin
                    digits_next[i] = BLANK_DIGIT;
                end
                pos_next = '0;
            end
            default:
            begin
                // tick and code issue touch only the timer
                pos_next = pos_reg;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Result evaluation on the state after this transaction
    // ---------------------------------------------------------------
    always_comb
    begin
        expected_pad = (4 * PadN)'(expected_reg);
        for (int i = 0; i < PadN; i++)
        begin
            digits_pad[i] = BLANK_DIGIT;
        end
        for (int i = 0; i < CODE_DIGITS; i++)
        begin
            digits_pad[i] = digits_next[i];
        end
    end

    // Slots beyond the expected register compare against zero; a blank never matches
    always_comb
    begin
        complete_next = 1'b1;
        digits_equal  = 1'b1;
        for (int i = 0; i < CODE_DIGITS; i++)
        begin
            if (digits_next[i] == BLANK_DIGIT)
            begin
                complete_next = 1'b0;
            end
            if (digits_next[i] != expected_pad[i])
            begin
                digits_equal = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg    <= {CODE_DIGITS{BLANK_DIGIT}};
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                digits_reg    <= digits_next;
                pos_reg       <= pos_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: hold while the consumer stalls
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            confirm_reg  <= confirm_next;
            complete_reg <= complete_next;
            expired_reg  <= expired_next;
            match_reg    <= complete_next && digits_equal && !expired_next;
            position_reg <= 3'(pos_next);
            display_reg  <= digits_pad[DISPLAY_DIGITS-1:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign confirm_ok      = confirm_reg;
    assign code_complete   = complete_reg;
    assign code_expired    = expired_reg;
    assign code_match      = match_reg;
    assign entry_position  = position_reg;
    assign entered_display = display_reg;

`ifndef SYNTHESIS
    a_match_implies: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && code_match) |-> (code_complete && !code_expired))
        else $error("match reported on an incomplete or expired entry");

    a_confirm_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && confirm_ok) |-> code_complete)
        else $error("confirm reported on an incomplete entry");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PosFull)
        else $error("entry position beyond slot count");

    a_clear_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (req_type == REQ_CLEAR)) |=> (pos_reg == '0))
        else $error("clear did not reset the entry position");
`endif

endmodule
